// ===== src/imre_pkg.sv =====
// Shared types and constants for the interval merge run emitter.
package imre_pkg;

  localparam int unsigned DefRegionDepth = 65536;
  localparam int unsigned CmdQDepth      = 4;

  // configuration register indexes
  localparam logic [2:0] CfgMaxMode   = 3'd0;
  localparam logic [2:0] CfgClipLevel = 3'd1;
  localparam logic [2:0] CfgAdjust    = 3'd2;
  localparam logic [2:0] CfgThreshold = 3'd3;
  localparam logic [2:0] CfgRegionLen = 3'd4;

  localparam logic ReqMerge = 1'b0;
  localparam logic ReqEmit  = 1'b1;

  // classified command handed from front to back
  typedef struct packed {
    logic        emit;
    logic [16:0] start;
    logic [16:0] stop;
    logic [31:0] value;
  } cmd_t;

  // saturate a 33-bit signed sum to 32 bits
  function automatic logic [31:0] sat33(input logic [32:0] x);
    logic [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/imre_front.sv =====
// Front end: clips values and cuts interval ends, queues commands for the back end.
module imre_front #(
  parameter int unsigned REGION_DEPTH = imre_pkg::DefRegionDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_req_type,
  input  logic [15:0]         in_interval_start,
  input  logic [16:0]         in_interval_end,
  input  logic signed [31:0]  in_interval_value,
  input  logic signed [31:0]  clip_level,
  input  logic [16:0]         region_len,
  output logic                q_valid,
  output imre_pkg::cmd_t      q_cmd,
  input  logic                q_take
);
  localparam int unsigned QW = $clog2(imre_pkg::CmdQDepth);

  imre_pkg::cmd_t q_mem_r [imre_pkg::CmdQDepth];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r;
  logic [16:0]   rlen_use;
  logic [16:0]   stop;
  logic [31:0]   val;
  imre_pkg::cmd_t cmd;
  logic push_ok;

  assign in_full = (cnt_r == (QW+1)'(imre_pkg::CmdQDepth));
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = q_mem_r[rp_r];

  // classify: clip the value, cut the end to the region in use
  always_comb begin
    rlen_use = ({15'd0, region_len} > 32'(REGION_DEPTH)) ? 17'(REGION_DEPTH) : region_len;
    stop = (in_interval_end > rlen_use) ? rlen_use : in_interval_end;
    val  = (in_interval_value > clip_level) ? clip_level : in_interval_value;
    cmd.emit  = (in_req_type == imre_pkg::ReqEmit);
    cmd.start = {1'b0, in_interval_start};
    cmd.stop  = stop;
    cmd.value = val;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_mem_r[wp_r] <= cmd;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_ok) wp_r <= wp_r + QW'(1);
      if (q_take)  rp_r <= rp_r + QW'(1);
      cnt_r <= cnt_r + (QW+1)'(push_ok) - (QW+1)'(q_take);
    end
  end
endmodule

// ===== src/imre_back.sv =====
// Back end: store, merge sweep, run scan with clearing and the result register.
module imre_back #(
  parameter int unsigned REGION_DEPTH = imre_pkg::DefRegionDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  imre_pkg::cmd_t     q_cmd,
  output logic               q_take,
  input  logic               max_mode,
  input  logic signed [31:0] adjust_offset,
  input  logic signed [31:0] output_threshold,
  input  logic [16:0]        region_len,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [15:0]        out_run_start,
  output logic [16:0]        out_run_end,
  output logic [31:0]        out_run_value,
  output logic               out_scan_done
);
  localparam int unsigned AW = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
  localparam int unsigned PW = AW + 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StMRd   = 3'd2;
  localparam logic [2:0] StMWr   = 3'd3;
  localparam logic [2:0] StSRd   = 3'd4;
  localparam logic [2:0] StSCmp  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [31:0] mem_r [REGION_DEPTH];
  logic [31:0] rd_r;
  logic        we;
  logic [AW-1:0] wa;
  logic [31:0] wd;
  logic        re;
  logic [AW-1:0] ra;

  logic [2:0]  st_r, st_nxt;
  logic [PW-1:0] pos_r, pos_nxt;      // sweep / scan position
  logic [PW-1:0] stop_r, stop_nxt;
  logic [PW-1:0] cur_r, cur_nxt;      // scan cursor
  logic [PW-1:0] rs_r, rs_nxt;        // run start
  logic [31:0] val_r, val_nxt;        // merge value or run value
  logic        mm_r, mm_nxt;
  logic        have_r, have_nxt;      // run value captured
  logic        ov_r, ov_nxt;
  logic [15:0] os_r, os_nxt;
  logic [16:0] oe_r, oe_nxt;
  logic [31:0] ovl_r, ovl_nxt;
  logic        od_r, od_nxt;
  logic [PW-1:0] len;
  logic [31:0] adj, merged;

  // region in use, capped at the store depth
  assign len = ({15'd0, region_len} > 32'(REGION_DEPTH)) ? PW'(REGION_DEPTH)
                                                        : PW'(region_len);

  always_ff @(posedge clk) begin
    if (we) mem_r[wa] <= wd;
    if (re) rd_r <= mem_r[ra];
  end

  assign adj = imre_pkg::sat33({val_r[31], val_r} + {adjust_offset[31], adjust_offset});
  assign merged = mm_r ? (($signed(rd_r) < $signed(val_r)) ? val_r : rd_r)
                       : imre_pkg::sat33({rd_r[31], rd_r} + {val_r[31], val_r});

  assign out_empty     = !ov_r;
  assign out_run_start = os_r;
  assign out_run_end   = oe_r;
  assign out_run_value = ovl_r;
  assign out_scan_done = od_r;

  always_comb begin
    st_nxt = st_r; pos_nxt = pos_r; stop_nxt = stop_r; cur_nxt = cur_r;
    rs_nxt = rs_r; val_nxt = val_r; mm_nxt = mm_r; have_nxt = have_r;
    ov_nxt = ov_r; os_nxt = os_r; oe_nxt = oe_r; ovl_nxt = ovl_r; od_nxt = od_r;
    we = 1'b0; wa = pos_r[AW-1:0]; wd = '0; re = 1'b0; ra = pos_r[AW-1:0];
    q_take = 1'b0;
    if (ov_r && out_pop) ov_nxt = 1'b0;
    unique case (st_r)
      StClear: begin
        we = 1'b1;
        pos_nxt = pos_r + PW'(1);
        if (pos_r == PW'(REGION_DEPTH - 1)) st_nxt = StIdle;
      end
      StIdle: begin
        if (q_valid && !(q_cmd.emit && ov_r)) begin
          q_take = 1'b1;
          if (!q_cmd.emit) begin
            cur_nxt  = '0;
            pos_nxt  = PW'(q_cmd.start);
            stop_nxt = PW'(q_cmd.stop);
            val_nxt  = q_cmd.value;
            mm_nxt   = max_mode;
            if ({15'd0, q_cmd.start} < {15'd0, q_cmd.stop}) st_nxt = StMRd;
          end else begin
            have_nxt = 1'b0;
            pos_nxt  = cur_r;
            st_nxt   = StSRd;
          end
        end
      end
      StMRd: begin
        re = 1'b1;
        st_nxt = StMWr;
      end
      StMWr: begin
        we = 1'b1; wd = merged;
        pos_nxt = pos_r + PW'(1);
        st_nxt = (pos_r + PW'(1) < stop_r) ? StMRd : StIdle;
      end
      StSRd: begin
        if (pos_r >= len) begin
          if (have_r) begin
            st_nxt = StOut;
          end else if (cur_r >= len) begin
            ov_nxt = 1'b1; os_nxt = '0; oe_nxt = '0; ovl_nxt = '0; od_nxt = 1'b1;
            st_nxt = StIdle;
          end else begin
            st_nxt = StOut;
          end
        end else begin
          re = 1'b1;
          st_nxt = StSCmp;
        end
      end
      StSCmp: begin
        // first entry of a run, or a match extending it; clear as we go
        if (!have_r || rd_r == val_r) begin
          if (!have_r) begin
            rs_nxt = pos_r; val_nxt = rd_r; have_nxt = 1'b1;
          end
          we = 1'b1;
          pos_nxt = pos_r + PW'(1);
          st_nxt = StSRd;
        end else begin
          st_nxt = StOut;
        end
      end
      StOut: begin
        cur_nxt = pos_r;
        have_nxt = 1'b0;
        if ($signed(adj) > output_threshold) begin
          ov_nxt = 1'b1;
          os_nxt = 16'(rs_r);
          oe_nxt = 17'(pos_r);
          ovl_nxt = adj;
          od_nxt = 1'b0;
          st_nxt = StIdle;
        end else begin
          st_nxt = StSRd;
        end
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StClear; pos_r <= '0; cur_r <= '0; have_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; pos_r <= pos_nxt; cur_r <= cur_nxt; have_r <= have_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stop_r <= stop_nxt; rs_r <= rs_nxt; val_r <= val_nxt; mm_r <= mm_nxt;
    os_r <= os_nxt; oe_r <= oe_nxt; ovl_r <= ovl_nxt; od_r <= od_nxt;
  end
endmodule

// ===== src/interval_merge_run_emitter.sv =====
// Interval merge run emitter: top level with configuration registers.
// Intervals are clipped and queued by the front end, then merged into a
// REGION_DEPTH-entry store by a read-modify-write sweep over each covered
// position (a read state, then a write state). An emit request walks the
// store from the kept cursor, clearing entries as it goes; a run closed by a
// differing entry leaves that entry to be read again for the next run. After
// reset the store is zeroed in a pass over every entry, during which no word
// is taken from the queue (up to four are buffered).
module interval_merge_run_emitter #(
  parameter int unsigned REGION_DEPTH = imre_pkg::DefRegionDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_req_type,
  input  logic [15:0] in_interval_start,
  input  logic [16:0] in_interval_end,
  input  logic signed [31:0] in_interval_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_run_start,
  output logic [16:0] out_run_end,
  output logic signed [31:0] out_run_value,
  output logic        out_scan_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic        max_mode_r;
  logic [31:0] clip_r, adj_r, thr_r;
  logic [16:0] rlen_r;
  logic        q_valid, q_take;
  imre_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_mode_r <= 1'b0; clip_r <= 32'h7FFF_FFFF; adj_r <= '0; thr_r <= '0;
      rlen_r <= 17'h10000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        imre_pkg::CfgMaxMode:   max_mode_r <= cfg_data[0];
        imre_pkg::CfgClipLevel: clip_r <= cfg_data;
        imre_pkg::CfgAdjust:    adj_r <= cfg_data;
        imre_pkg::CfgThreshold: thr_r <= cfg_data;
        imre_pkg::CfgRegionLen: rlen_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  imre_front #(.REGION_DEPTH(REGION_DEPTH)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_interval_start,
    .in_interval_end, .in_interval_value,
    .clip_level(clip_r), .region_len(rlen_r),
    .q_valid, .q_cmd, .q_take
  );

  imre_back #(.REGION_DEPTH(REGION_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take,
    .max_mode(max_mode_r), .adjust_offset(adj_r), .output_threshold(thr_r),
    .region_len(rlen_r),
    .out_empty, .out_pop, .out_run_start, .out_run_end, .out_run_value,
    .out_scan_done
  );
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the interval merge run emitter.
`timescale 1ns / 1ps

module tb_top;

  // one expected result word
  typedef struct {
    bit [15:0] run_start;
    bit [16:0] run_end;
    bit [31:0] run_value;
    bit        done;
  } run_word_t;

  // coverage store predictor and expected-run queue
  class run_scoreboard;
    int          cov_store[65536];
    int          cursor;
    bit          max_mode;
    int          clip_level;
    int          adjust;
    int          threshold;
    bit [16:0]   region_len;
    run_word_t   runs_due[$];
    int          fails;

    function new();
      cursor     = 0;
      max_mode   = 1'b0;
      clip_level = 32'h7FFF_FFFF;
      adjust     = 0;
      threshold  = 0;
      region_len = 17'd65536;
      fails      = 0;
    endfunction

    function int span();
      return (region_len > 17'd65536) ? 65536 : int'(region_len);
    endfunction

    function int sat(longint x);
      if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (x < -64'sh8000_0000) return 32'h8000_0000;
      return int'(x);
    endfunction

    function void write_reg(bit [2:0] idx, bit [31:0] d);
      case (idx)
        imre_pkg::CfgMaxMode:   max_mode   = d[0];
        imre_pkg::CfgClipLevel: clip_level = d;
        imre_pkg::CfgAdjust:    adjust     = d;
        imre_pkg::CfgThreshold: threshold  = d;
        imre_pkg::CfgRegionLen: region_len = d[16:0];
        default: ;
      endcase
    endfunction

    // note an accepted input word and work out its result, if any
    function void note_word(bit req, bit [15:0] s, bit [16:0] e, int v);
      int len;
      int lo;
      int hi;
      int x;
      int val;
      run_word_t w;
      len = span();
      if (req == imre_pkg::ReqMerge) begin
        if (v > clip_level) v = clip_level;
        hi = (int'(e) > len) ? len : int'(e);
        for (int p = int'(s); p < hi; p++) begin
          if (max_mode) begin
            if (cov_store[p] < v) cov_store[p] = v;
          end else begin
            cov_store[p] = sat(longint'(cov_store[p]) + longint'(v));
          end
        end
        cursor = 0;
        return;
      end
      while (cursor < len) begin
        lo = cursor;
        hi = lo + 1;
        x  = cov_store[lo];
        while (hi < len && cov_store[hi] == x) hi++;
        for (int p = lo; p < hi; p++) cov_store[p] = 0;
        cursor = hi;
        val = sat(longint'(x) + longint'(adjust));
        if (val > threshold) begin
          w.run_start = lo[15:0];
          w.run_end   = hi[16:0];
          w.run_value = val;
          w.done      = 1'b0;
          runs_due.push_back(w);
          return;
        end
      end
      w.run_start = '0;
      w.run_end   = '0;
      w.run_value = '0;
      w.done      = 1'b1;
      runs_due.push_back(w);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fails++;
    endtask

    // compare a popped word with the oldest expected run
    task check_run(bit [15:0] rs, bit [16:0] re, bit [31:0] rv, bit done);
      run_word_t w;
      if (runs_due.size() == 0) begin
        report($sformatf("unexpected word %0d %0d %h %0d", rs, re, rv, done));
      end else begin
        w = runs_due.pop_front();
        if (rs !== w.run_start)
          report($sformatf("run_start %0d, want %0d", rs, w.run_start));
        if (re !== w.run_end)
          report($sformatf("run_end %0d, want %0d", re, w.run_end));
        if (rv !== w.run_value)
          report($sformatf("run_value %h, want %h", rv, w.run_value));
        if (done !== w.done)
          report($sformatf("scan_done %0d, want %0d", done, w.done));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic        in_req_type = 1'b0;
  logic [15:0] in_interval_start = '0;
  logic [16:0] in_interval_end = '0;
  logic signed [31:0] in_interval_value = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_run_start;
  logic [16:0] out_run_end;
  logic signed [31:0] out_run_value;
  logic        out_scan_done;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  run_scoreboard sb = new();
  int send_idle_pct = 0;
  int stall_pct = 0;

  interval_merge_run_emitter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_req_type(in_req_type),
    .in_interval_start(in_interval_start), .in_interval_end(in_interval_end),
    .in_interval_value(in_interval_value),
    .out_empty(out_empty), .out_pop(out_pop), .out_run_start(out_run_start),
    .out_run_end(out_run_end), .out_run_value(out_run_value),
    .out_scan_done(out_scan_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // result side: check popped words, stall at random
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_run(out_run_start, out_run_end, out_run_value, out_scan_done);
    out_pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // hard stop
  initial begin
    #40_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task push_word(bit req, bit [15:0] s, bit [16:0] e, bit [31:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push           <= 1'b1;
    in_req_type       <= req;
    in_interval_start <= s;
    in_interval_end   <= e;
    in_interval_value <= v;
    do @(posedge clk); while (in_full);
    sb.note_word(req, s, e, v);
  endtask

  // valid is left high; the caller drops it after the last write
  task write_cfg(bit [2:0] idx, bit [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task set_regs(bit mode, bit [31:0] clip, bit [31:0] adj, bit [31:0] thr,
                bit [16:0] rlen);
    write_cfg(imre_pkg::CfgMaxMode, {31'd0, mode});
    write_cfg(imre_pkg::CfgClipLevel, clip);
    write_cfg(imre_pkg::CfgAdjust, adj);
    write_cfg(imre_pkg::CfgThreshold, thr);
    write_cfg(imre_pkg::CfgRegionLen, {15'd0, rlen});
    cfg_valid <= 1'b0;
  endtask

  // every phase ends on an emit, so an empty queue means the block is idle
  task settle();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.runs_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function bit [31:0] pick_q();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'h0001_0000;
      4: return 32'hFFFF_0000;
      5: return 32'h0002_0000;
      default: return 32'h0;
    endcase
  endfunction

  function bit [31:0] pick_thr();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return -$urandom_range(0, 32'h0003_0000);
    endcase
  endfunction

  task random_merge(int len);
    bit [15:0] s;
    bit [16:0] e;
    if ($urandom_range(0, 9) == 0) s = $urandom();
    else s = $urandom_range(0, len);
    if ($urandom_range(0, 9) == 0) e = $urandom();
    else e = s + $urandom_range(0, len);
    push_word(imre_pkg::ReqMerge, s, e, pick_q());
  endtask

  // groups of merges followed by emits, with stray merges mid-scan
  task random_phase(int n);
    int len;
    int sent;
    len  = sb.span();
    sent = 0;
    while (sent < n) begin
      repeat ($urandom_range(1, 4)) begin
        random_merge(len);
        sent++;
      end
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 11) == 0) begin
          random_merge(len);
          sent++;
        end
        push_word(imre_pkg::ReqEmit, $urandom(), $urandom(), $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturation, clipping to region, empty spans, mid-scan restart
    send_idle_pct = 0;
    stall_pct = 0;
    set_regs(1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0, 17'd16);
    push_word(imre_pkg::ReqMerge, 16'd0, 17'd4, 32'h7FFF_FFFF);
    push_word(imre_pkg::ReqMerge, 16'd2, 17'd6, 32'h7FFF_FFFF);
    push_word(imre_pkg::ReqMerge, 16'd8, 17'd20, 32'h8000_0000);
    push_word(imre_pkg::ReqMerge, 16'd10, 17'd12, 32'h8000_0000);
    push_word(imre_pkg::ReqMerge, 16'd5, 17'd5, 32'h0001_0000);
    push_word(imre_pkg::ReqMerge, 16'hFFFF, 17'h1FFFF, 32'h0001_0000);
    repeat (4) push_word(imre_pkg::ReqEmit, 16'hFFFF, 17'h1FFFF, 32'hFFFF_FFFF);
    push_word(imre_pkg::ReqMerge, 16'd0, 17'd16, 32'h0001_0000);
    push_word(imre_pkg::ReqEmit, 16'd0, 17'd0, 32'd0);
    push_word(imre_pkg::ReqMerge, 16'd3, 17'd4, 32'h0000_0005);
    repeat (5) push_word(imre_pkg::ReqEmit, 16'd0, 17'd0, 32'd0);
    settle();

    // max mode with a low ceiling
    set_regs(1'b1, 32'h0000_8000, 32'h8000_0000, 32'h8000_0000, 17'd1);
    push_word(imre_pkg::ReqMerge, 16'd0, 17'd1, 32'h0001_0000);
    push_word(imre_pkg::ReqMerge, 16'd0, 17'd9, 32'hFFFF_0000);
    repeat (3) push_word(imre_pkg::ReqEmit, 16'd0, 17'd0, 32'd0);
    settle();

    // empty region
    set_regs(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 17'd0);
    push_word(imre_pkg::ReqMerge, 16'd0, 17'd3, 32'h0001_0000);
    repeat (2) push_word(imre_pkg::ReqEmit, 16'd0, 17'd0, 32'd0);
    settle();

    // random phases, idling pattern rotating
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      set_regs($urandom_range(0, 1), pick_q(), pick_q(), pick_thr(),
               $urandom_range(1, 48));
      random_phase(150);
      settle();
    end

    // full region, oversize length register; few emits as each walks far
    send_idle_pct = 31;
    stall_pct = 31;
    set_regs(1'b0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 17'h1FFFF);
    push_word(imre_pkg::ReqMerge, 16'd100, 17'd120, 32'h0003_0000);
    push_word(imre_pkg::ReqMerge, 16'd65530, 17'h1FFFF, 32'hFFFF_0000);
    repeat (4) push_word(imre_pkg::ReqEmit, 16'd0, 17'd0, 32'd0);
    settle();

    repeat (50) @(posedge clk);
    if (sb.fails == 0 && sb.runs_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
